>>> hdl/anagram_group_by_letter_counts_defines.svh
// Assertion macros shared by the anagram grouping block.
`ifndef ANAGRAM_GROUP_BY_LETTER_COUNTS_DEFINES_SVH
`define ANAGRAM_GROUP_BY_LETTER_COUNTS_DEFINES_SVH

`ifndef SYNTHESIS
`define AGBL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AGBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AGBL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define AGBL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/agbl_pkg.sv
// Types and constants of the anagram grouping block.
package agbl_pkg;

    localparam int LETTER_W    = 5;
    localparam int GROUP_ID_W  = 6;
    localparam int COUNT_W     = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        ST_GROUPED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                end_of_word;
        logic                new_list;
    } t_in;

    typedef struct packed {
        logic [GROUP_ID_W-1:0] group_id;
        logic                  new_group;
        t_status               status;
    } t_out;

    typedef struct packed {
        logic clear;
        logic word;
        logic overlong;
    } t_cmd;

endpackage

>>> hdl/agbl_front.sv
// Front end: builds the letter-count signature of the current word.
module agbl_front #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_WORD_LEN  = 63
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_take,
    input  agbl_pkg::t_in                              i_in,
    output logic                                       o_push,
    output agbl_pkg::t_cmd                             o_cmd,
    output logic [ALPHABET_SIZE*agbl_pkg::COUNT_W-1:0] o_sig
);

    localparam int CW   = agbl_pkg::COUNT_W;
    localparam int LENW = $clog2(MAX_WORD_LEN + 1);

    logic [CW-1:0]   r_counts [ALPHABET_SIZE];
    logic [CW-1:0]   n_counts [ALPHABET_SIZE];
    logic [LENW-1:0] r_len;
    logic            r_over;
    logic            in_range;
    logic            take_letter;
    logic            hit_sat;
    logic            too_long;
    logic            inc;
    logic            n_over;

    always_comb begin
        in_range    = 7'(i_in.letter) < 7'(ALPHABET_SIZE);
        take_letter = in_range && !r_over;
        hit_sat     = 1'b0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if ((7'(i_in.letter) == 7'(i)) && (r_counts[i] == agbl_pkg::COUNT_MAX)) begin
                hit_sat = 1'b1;
            end
        end
        too_long = take_letter && ((r_len >= LENW'(MAX_WORD_LEN)) || hit_sat);
        inc      = take_letter && !too_long;
        n_over   = r_over || too_long;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            n_counts[i] = r_counts[i]
                        + CW'(inc && (7'(i_in.letter) == 7'(i)));
            o_sig[i*CW +: CW] = n_counts[i];
        end
        o_push         = i_take && (i_in.end_of_word || i_in.new_list);
        o_cmd.clear    = i_in.new_list;
        o_cmd.word     = i_in.end_of_word;
        o_cmd.overlong = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_counts[i] <= '0;
            end
            r_len  <= '0;
            r_over <= 1'b0;
        end else if (i_take) begin
            if (i_in.end_of_word) begin
                for (int i = 0; i < ALPHABET_SIZE; i++) begin
                    r_counts[i] <= '0;
                end
                r_len  <= '0;
                r_over <= 1'b0;
            end else begin
                for (int i = 0; i < ALPHABET_SIZE; i++) begin
                    r_counts[i] <= n_counts[i];
                end
                r_len  <= r_len + LENW'(inc);
                r_over <= n_over;
            end
        end
    end

endmodule

>>> hdl/agbl_queue.sv
// Short queue of finished words and list clears between front and back end.
module agbl_queue #(
    parameter int W = 159
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_valid,
    output logic         o_full
);

    localparam int DEPTH = agbl_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [W-1:0]    r_data [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_data  = r_data[r_rp];
    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CNTW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/agbl_back.sv
// Back end: searches the signature table and opens new groups.
module agbl_back #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_GROUPS    = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_valid,
    input  agbl_pkg::t_cmd                             i_q_cmd,
    input  logic [ALPHABET_SIZE*agbl_pkg::COUNT_W-1:0] i_q_sig,
    output logic                                       o_q_pop,
    output logic                                       o_valid,
    output agbl_pkg::t_out                             o_result
);

    localparam int SIGW = ALPHABET_SIZE * agbl_pkg::COUNT_W;
    localparam int GW   = $clog2(MAX_GROUPS);
    localparam int UW   = GW + 1;
    localparam int IDW  = agbl_pkg::GROUP_ID_W;

    agbl_pkg::t_state r_state, n_state;
    logic [UW-1:0]    r_used, n_used;
    logic [UW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [GW-1:0]    r_pend_idx, n_pend_idx;
    logic [SIGW-1:0]  r_sig, n_sig;
    logic             r_out_valid, n_out_valid;
    agbl_pkg::t_out   r_out, n_out;
    logic [SIGW-1:0]  r_mem [MAX_GROUPS];
    logic [SIGW-1:0]  r_rd_data;
    logic             rd_en;
    logic             wr_en;
    logic             match;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_sig       = r_sig;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        match       = r_pend && (r_rd_data == r_sig);
        case (r_state)
            agbl_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_sig   = i_q_sig;
                    n_idx   = '0;
                    if (i_q_cmd.clear) begin
                        n_used = '0;
                    end
                    if (i_q_cmd.word) begin
                        if (i_q_cmd.overlong) begin
                            n_out_valid     = 1'b1;
                            n_out.group_id  = '0;
                            n_out.new_group = 1'b0;
                            n_out.status    = agbl_pkg::ST_TOO_LONG;
                        end else begin
                            n_state = agbl_pkg::S_SEARCH;
                        end
                    end
                end
            end
            agbl_pkg::S_SEARCH: begin
                if (match) begin
                    n_out_valid     = 1'b1;
                    n_out.group_id  = IDW'(r_pend_idx);
                    n_out.new_group = 1'b0;
                    n_out.status    = agbl_pkg::ST_GROUPED;
                    n_state         = agbl_pkg::S_IDLE;
                end else if (r_idx < r_used) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[GW-1:0];
                    n_idx      = r_idx + 1'b1;
                end else if (r_used < UW'(MAX_GROUPS)) begin
                    wr_en           = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out.group_id  = IDW'(r_used);
                    n_out.new_group = 1'b1;
                    n_out.status    = agbl_pkg::ST_GROUPED;
                    n_used          = r_used + 1'b1;
                    n_state         = agbl_pkg::S_IDLE;
                end else begin
                    n_out_valid     = 1'b1;
                    n_out.group_id  = '0;
                    n_out.new_group = 1'b0;
                    n_out.status    = agbl_pkg::ST_FULL;
                    n_state         = agbl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = agbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= agbl_pkg::S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_sig      <= n_sig;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_used[GW-1:0]] <= r_sig;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[GW-1:0]];
        end
    end

endmodule

>>> hdl/anagram_group_by_letter_counts.sv
// Top level of the anagram grouping block: letter front end, word queue, table back end.
// A letter is taken each cycle while the two-entry queue of finished words has room.
// A result follows its end-of-word letter through the queue and, unless the word is too long,
// a search of the table; results come in word order and the table reads one group a cycle.
// A lookup holds the back end until it ends, so the queue may fill; no result stalls.
// Synchronous active-low reset clears the counts, group count and queue, not the table.
`include "anagram_group_by_letter_counts_defines.svh"

module anagram_group_by_letter_counts #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_GROUPS    = 64,
    parameter int MAX_WORD_LEN  = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  agbl_pkg::t_in  i_in,
    output logic           o_valid,
    output agbl_pkg::t_out o_result
);

    localparam int SIGW = ALPHABET_SIZE * agbl_pkg::COUNT_W;
    localparam int CMDW = $bits(agbl_pkg::t_cmd);
    localparam int QW   = CMDW + SIGW;

    logic           w_take;
    logic           w_push;
    agbl_pkg::t_cmd w_push_cmd;
    logic [SIGW-1:0] w_push_sig;
    logic [QW-1:0]  w_q_data;
    logic           w_q_valid;
    logic           w_full;
    logic           w_pop;
    agbl_pkg::t_cmd w_q_cmd;
    logic [SIGW-1:0] w_q_sig;

    assign busy     = w_full;
    assign w_take   = start && !w_full;
    assign w_q_cmd  = w_q_data[SIGW +: CMDW];
    assign w_q_sig  = w_q_data[SIGW-1:0];

    agbl_front #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_in   (i_in),
        .o_push (w_push),
        .o_cmd  (w_push_cmd),
        .o_sig  (w_push_sig)
    );

    agbl_queue #(
        .W(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_push_cmd, w_push_sig}),
        .i_pop  (w_pop),
        .o_data (w_q_data),
        .o_valid(w_q_valid),
        .o_full (w_full)
    );

    agbl_back #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .MAX_GROUPS   (MAX_GROUPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_cmd  (w_q_cmd),
        .i_q_sig  (w_q_sig),
        .o_q_pop  (w_pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `AGBL_ASSERT_IMPLIES(a_pop_needs_word, i_clk, i_rst_n, w_pop, w_q_valid)
    `AGBL_ASSERT_IMPLIES(a_push_needs_room, i_clk, i_rst_n, w_push, !w_full)
    `AGBL_ASSERT_IMPLIES(a_ungrouped_clean, i_clk, i_rst_n,
        o_valid && (o_result.status != agbl_pkg::ST_GROUPED),
        (o_result.group_id == '0) && !o_result.new_group)

endmodule

>>> test/word_group_checker.sv
// Checker for the anagram grouping block: predicts the group of each finished word and compares.
module word_group_checker
    import agbl_pkg::*;
#(
    parameter int ALPHABET = 26,
    parameter int GROUPS   = 64,
    parameter int WORD_MAX = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_in,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_mismatches,
    output int   o_pending
);

    typedef logic [ALPHABET-1:0][COUNT_W-1:0] t_signature;

    t_signature word_counts;
    logic       word_too_long;
    t_signature group_signatures [GROUPS];
    logic       group_live [GROUPS];
    int         groups_in_use;
    t_out       expected_groups [$];
    int         mismatch_total = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic void note_mismatch(input t_out want, input t_out got,
                                          input logic unexpected);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            if (unexpected) begin
                $display("Unexpected result: group %0d new %0b status %0d",
                         got.group_id, got.new_group, got.status);
            end else begin
                $display("Mismatch: expected group %0d new %0b status %0d, ",
                         want.group_id, want.new_group, want.status,
                         "got group %0d new %0b status %0d",
                         got.group_id, got.new_group, got.status);
            end
        end
    endfunction

    function automatic void absorb_letter(input t_in w);
        int   len;
        int   hit_id;
        t_out r;
        if (w.new_list) begin
            for (int g = 0; g < GROUPS; g++) begin
                group_live[g] = 1'b0;
            end
            groups_in_use = 0;
        end
        if (w.letter < ALPHABET && !word_too_long) begin
            len = 0;
            for (int k = 0; k < ALPHABET; k++) begin
                len += int'(word_counts[k]);
            end
            if (len + 1 > WORD_MAX || word_counts[w.letter] >= COUNT_MAX) begin
                word_too_long = 1'b1;
            end else begin
                word_counts[w.letter] = word_counts[w.letter] + 1'b1;
            end
        end
        if (!w.end_of_word) begin
            return;
        end
        r = '{group_id: '0, new_group: 1'b0, status: ST_GROUPED};
        if (word_too_long) begin
            r.status = ST_TOO_LONG;
        end else begin
            hit_id = -1;
            for (int g = 0; g < groups_in_use; g++) begin
                if (hit_id < 0 && group_live[g] && group_signatures[g] == word_counts) begin
                    hit_id = g;
                end
            end
            if (hit_id >= 0) begin
                r.group_id = GROUP_ID_W'(hit_id);
            end else if (groups_in_use < GROUPS) begin
                group_signatures[groups_in_use] = word_counts;
                group_live[groups_in_use] = 1'b1;
                r.group_id = GROUP_ID_W'(groups_in_use);
                r.new_group = 1'b1;
                groups_in_use++;
            end else begin
                r.status = ST_FULL;
            end
        end
        expected_groups.insert(expected_groups.size(), r);
        word_counts = '0;
        word_too_long = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            word_counts = '0;
            word_too_long = 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                group_live[g] = 1'b0;
            end
            groups_in_use = 0;
            expected_groups.delete();
        end else begin
            if (i_valid) begin
                if (expected_groups.size() == 0) begin
                    note_mismatch('0, i_result, 1'b1);
                end else begin
                    want = expected_groups.pop_front();
                    if (want.group_id != i_result.group_id
                            || want.new_group != i_result.new_group
                            || want.status != i_result.status) begin
                        note_mismatch(want, i_result, 1'b0);
                    end
                end
            end
            if (i_start && !i_busy) begin
                absorb_letter(i_in);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending <= expected_groups.size();
    end

endmodule

>>> test/testbench.sv
// Top of the anagram grouping testbench: clock, reset, letter stimulus and the verdict.
module testbench;
    import agbl_pkg::*;

    localparam int ALPHABET      = 26;
    localparam int GROUPS        = 64;
    localparam int WORD_MAX      = 63;
    localparam int LETTER_TARGET = 1250;
    localparam int QUIET_FROM    = 1000;
    localparam int LETTER_TOP    = (1 << LETTER_W) - 1;
    localparam int KEPT_LEN      = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  i_in    = '0;
    logic o_valid;
    t_out o_result;
    int   mismatches;
    int   words_pending;

    logic [LETTER_W-1:0]          spelling [0:79];
    int                           spelling_len;
    logic [KEPT_LEN*LETTER_W-1:0] past_spelling [$];
    int                           past_len [$];
    int                           letters_sent = 0;

    anagram_group_by_letter_counts #(
        .ALPHABET_SIZE(ALPHABET),
        .MAX_GROUPS   (GROUPS),
        .MAX_WORD_LEN (WORD_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    word_group_checker #(
        .ALPHABET(ALPHABET),
        .GROUPS  (GROUPS),
        .WORD_MAX(WORD_MAX)
    ) group_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .o_mismatches(mismatches),
        .o_pending   (words_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_letter(input logic [LETTER_W-1:0] l, input logic eow,
                               input logic clear);
        int pause;
        if (letters_sent < QUIET_FROM && $urandom_range(0, 6) == 0) begin
            pause = $urandom_range(1, 4);
            start <= 1'b0;
            i_in <= '{letter: LETTER_W'($urandom), end_of_word: 1'($urandom),
                      new_list: 1'($urandom)};
            repeat (pause) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= '{letter: l, end_of_word: eow, new_list: clear};
        do @(posedge i_clk); while (busy);
        letters_sent++;
    endtask

    task automatic spell_word(input logic clear);
        logic [KEPT_LEN*LETTER_W-1:0] kept;
        for (int i = 0; i < spelling_len; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_letter(LETTER_W'($urandom_range(ALPHABET, LETTER_TOP)), 1'b0, 1'b0);
            end
            send_letter(spelling[i], 1'(i == spelling_len - 1),
                        (i == 0 && clear) || $urandom_range(0, 399) == 0);
        end
        if (spelling_len <= KEPT_LEN) begin
            kept = '0;
            for (int i = 0; i < spelling_len; i++) begin
                kept[i*LETTER_W +: LETTER_W] = spelling[i];
            end
            past_spelling.insert(past_spelling.size(), kept);
            past_len.insert(past_len.size(), spelling_len);
        end
    endtask

    initial begin
        int                           list_left;
        logic                         fill_list;
        logic                         first_list;
        logic                         clear;
        int                           kind;
        int                           pick;
        int                           swap_at;
        int                           top_letter;
        logic [LETTER_W-1:0]          held;
        logic [KEPT_LEN*LETTER_W-1:0] kept;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_letter(5'd0, 1'b1, 1'b1);
        send_letter(5'd25, 1'b1, 1'b0);
        send_letter(5'd1, 1'b0, 1'b0);
        send_letter(5'd0, 1'b1, 1'b0);
        send_letter(5'd0, 1'b0, 1'b0);
        send_letter(5'd1, 1'b1, 1'b0);
        send_letter(5'd31, 1'b1, 1'b0);
        send_letter(5'd26, 1'b0, 1'b0);
        send_letter(5'd0, 1'b1, 1'b0);
        send_letter(5'd2, 1'b0, 1'b0);
        send_letter(5'd3, 1'b0, 1'b1);
        send_letter(5'd2, 1'b1, 1'b0);
        send_letter(5'd3, 1'b0, 1'b0);
        send_letter(5'd2, 1'b0, 1'b0);
        send_letter(5'd2, 1'b1, 1'b0);
        send_letter(5'd16, 1'b1, 1'b1);
        send_letter(5'd27, 1'b1, 1'b0);

        list_left = 0;
        first_list = 1'b1;
        fill_list = 1'b0;
        while (letters_sent < LETTER_TARGET) begin
            clear = 1'b0;
            if (list_left == 0) begin
                clear = 1'b1;
                past_spelling.delete();
                past_len.delete();
                fill_list = first_list || $urandom_range(0, 5) == 0;
                first_list = 1'b0;
                list_left = fill_list ? $urandom_range(90, 120) : $urandom_range(5, 30);
            end
            list_left--;
            kind = $urandom_range(0, 99);
            if (kind < 40 && past_len.size() != 0 && !(fill_list && kind < 25)) begin
                pick = $urandom_range(0, past_len.size() - 1);
                kept = past_spelling[pick];
                spelling_len = past_len[pick];
                for (int i = 0; i < spelling_len; i++) begin
                    spelling[i] = kept[i*LETTER_W +: LETTER_W];
                end
                for (int i = spelling_len - 1; i > 0; i--) begin
                    swap_at = $urandom_range(0, i);
                    held = spelling[i];
                    spelling[i] = spelling[swap_at];
                    spelling[swap_at] = held;
                end
            end else if (kind < 90) begin
                spelling_len = kind >= 80 ? $urandom_range(1, 2) : $urandom_range(1, 7);
                top_letter = (fill_list || $urandom_range(0, 1) == 1)
                             ? ALPHABET - 1 : $urandom_range(2, 6);
                for (int i = 0; i < spelling_len; i++) begin
                    spelling[i] = LETTER_W'($urandom_range(0, top_letter));
                end
            end else if (kind < 96) begin
                spelling_len = $urandom_range(WORD_MAX - 5, WORD_MAX + 3);
                held = LETTER_W'($urandom_range(0, ALPHABET - 1));
                top_letter = $urandom_range(0, 1);
                for (int i = 0; i < spelling_len; i++) begin
                    spelling[i] = top_letter == 1 ? held : LETTER_W'($urandom_range(0, 3));
                end
            end else begin
                spelling_len = 1;
                spelling[0] = LETTER_W'($urandom_range(ALPHABET, LETTER_TOP));
            end
            spell_word(clear);
        end
        start <= 1'b0;

        while (words_pending != 0) @(posedge i_clk);
        repeat (GROUPS + 16) @(posedge i_clk);
        if (mismatches == 0 && words_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
